// ===== src/tcr_pkg.sv =====
// Shared types and constants of the touch controller command/report engine.
// No dependencies.
package tcr_pkg;

  localparam int IMG_BYTES = 12;   // bytes of the frame that a reply or report can set
  localparam int IDX_W     = 4;    // byte_index width
  localparam int IN_W      = 160;  // packed input item, byte aligned
  localparam int OUT_W     = 24;   // packed result item, byte aligned

  localparam logic [1:0] MODE_COMMAND  = 2'd0;
  localparam logic [1:0] MODE_REPORT   = 2'd1;
  localparam logic [1:0] MODE_TX_DONE  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_LEN  = 2'd1;
  localparam logic [1:0] STAT_IGNORED  = 2'd2;

  localparam logic [7:0] CMD_VERSION   = 8'd0;
  localparam logic [7:0] CMD_RD_BASE   = 8'd1;
  localparam logic [7:0] CMD_RD_LPRESS = 8'd2;
  localparam logic [7:0] CMD_SAVE_BASE = 8'd3;
  localparam logic [7:0] CMD_WR_LPRESS = 8'd4;
  localparam logic [7:0] CMD_FW_UPDATE = 8'd5;
  localparam logic [7:0] CMD_SENSOR    = 8'd6;

  localparam logic [7:0] RPL_RD_BASE   = 8'd3;
  localparam logic [7:0] RPL_RD_LPRESS = 8'd4;
  localparam logic [7:0] RPL_SAVE_BASE = 8'd5;
  localparam logic [7:0] RPL_WR_LPRESS = 8'd7;
  localparam logic [7:0] RPL_FW_UPDATE = 8'd2;
  localparam logic [7:0] RPL_SENSOR    = 8'd8;

  localparam logic [7:0]  REPLY_MARK    = 8'h17;
  localparam logic [7:0]  FILL_BYTE     = 8'h5A;
  localparam logic [7:0]  REJECT_BYTE   = 8'hFF;
  localparam logic [15:0] SAVE_THRESH   = 16'd49;
  localparam logic [15:0] LPRESS_RESET  = 16'd1000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [7:0]  MIN_WR_LEN    = 8'd3;

  // version reply, byte 0 in the lowest bits
  localparam logic [63:0] VERSION_IMG = 64'h0202_0001_0100_0202;

  typedef struct packed {
    logic                   load;    // frame changes with this item
    logic                   fill;    // frame is all FILL_BYTE
    logic [IMG_BYTES*8-1:0] img;     // bytes 0..11, higher bytes read zero
    logic [1:0]             status;
    logic                   attention;
    logic                   upd;
    logic                   sav;
  } desc_t;

endpackage

// ===== src/tcr_front.sv =====
// Front end: accepts items, runs commands and report builds against the
// stored settings, and emits one frame descriptor per item. Uses tcr_pkg.
module tcr_front #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [tcr_pkg::IN_W-1:0] data_i,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  push_o,
  output tcr_pkg::desc_t        desc_o,
  input  logic                  full_i
);
  import tcr_pkg::*;

  logic [7:0]  code, flen;
  logic [15:0] set_value, base_now, chan_now, prox_now, gest_now, sens0, sens1;
  logic [23:0] payload;
  logic        save_acc;

  assign code      = data_i[7:0];
  assign flen      = data_i[15:8];
  assign set_value = data_i[31:16];
  assign payload   = data_i[55:32];
  assign base_now  = data_i[71:56];
  assign chan_now  = data_i[87:72];
  assign prox_now  = data_i[103:88];
  assign gest_now  = data_i[119:104];
  assign sens0     = data_i[135:120];
  assign sens1     = data_i[151:136];
  assign save_acc  = data_i[152];

  logic [15:0] baseline_q, baseline_d, lpress_q, lpress_d;
  logic [15:0] timeout_q, timeout_d, tload_q;
  logic        save_pend_q, save_pend_d, dirty_a_q, dirty_a_d, dirty_b_q, dirty_b_d;
  logic        waiting_q, waiting_d, attn_q, attn_d;

  logic        accept, len_bad;
  logic [16:0] diff;
  logic [15:0] diff_abs;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign len_bad    = (flen == 8'd0) || (flen > 8'(FRAME_BYTES));
  assign diff       = {1'b0, base_now} - {1'b0, baseline_q};
  assign diff_abs   = diff[16] ? (baseline_q - base_now) : diff[15:0];

  function automatic logic [IMG_BYTES*8-1:0] reply(input logic [7:0] rc, input logic [7:0] st,
                                                   input logic [15:0] w);
    reply = {56'd0, w, REPLY_MARK, st, rc};
  endfunction

  always_comb begin
    baseline_d  = baseline_q;
    lpress_d    = lpress_q;
    save_pend_d = save_pend_q;
    dirty_a_d   = dirty_a_q;
    dirty_b_d   = dirty_b_q;
    waiting_d   = waiting_q;
    timeout_d   = timeout_q;
    attn_d      = attn_q;
    desc_o      = '0;
    desc_o.status = STAT_OK;
    case (mode_i)
      MODE_COMMAND: begin
        if (len_bad) begin
          desc_o.status = STAT_BAD_LEN;
        end else begin
          desc_o.load = 1'b1;
          case (code)
            CMD_VERSION:   desc_o.img = {32'd0, VERSION_IMG};
            CMD_RD_BASE:   desc_o.img = reply(RPL_RD_BASE, 8'd0, baseline_q);
            CMD_RD_LPRESS: desc_o.img = reply(RPL_RD_LPRESS, 8'd0, lpress_q);
            CMD_SAVE_BASE: begin
              save_pend_d = 1'b1;
              desc_o.img  = reply(RPL_SAVE_BASE, 8'd0, 16'd0);
            end
            CMD_WR_LPRESS: begin
              if (flen < MIN_WR_LEN) begin
                desc_o.load   = 1'b0;
                desc_o.status = STAT_BAD_LEN;
              end else if (set_value == 16'd0) begin
                desc_o.img = reply(RPL_WR_LPRESS, REJECT_BYTE, 16'd0);
              end else begin
                lpress_d   = set_value;
                dirty_a_d  = 1'b1;
                dirty_b_d  = 1'b1;
                desc_o.img = reply(RPL_WR_LPRESS, 8'd0, 16'd0);
              end
            end
            CMD_FW_UPDATE: begin
              desc_o.upd = 1'b1;
              desc_o.img = reply(RPL_FW_UPDATE, 8'd0, 16'd0);
            end
            CMD_SENSOR: desc_o.img = {56'd0, sens1, sens0, RPL_SENSOR};
            default: begin
              desc_o.load   = 1'b0;
              desc_o.status = STAT_IGNORED;
            end
          endcase
        end
      end
      MODE_REPORT: begin
        desc_o.load = 1'b1;
        desc_o.img  = {gest_now, prox_now, chan_now, base_now, payload, code};
        if (save_pend_q) begin
          if (diff_abs > SAVE_THRESH) begin
            desc_o.sav = 1'b1;
            if (save_acc) baseline_d = base_now;
          end
          save_pend_d = 1'b0;
        end
        waiting_d = 1'b1;
        timeout_d = tload_q;
        attn_d    = 1'b1;
      end
      MODE_TX_DONE: begin
        desc_o.load = 1'b1;
        desc_o.fill = 1'b1;
        waiting_d   = 1'b0;
        timeout_d   = 16'd0;
        attn_d      = 1'b0;
      end
      default: desc_o.status = STAT_IGNORED;
    endcase
    desc_o.attention = attn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q  <= 16'd0;
      lpress_q    <= LPRESS_RESET;
      save_pend_q <= 1'b0;
      dirty_a_q   <= 1'b0;
      dirty_b_q   <= 1'b0;
      waiting_q   <= 1'b0;
      timeout_q   <= 16'd0;
      attn_q      <= 1'b0;
      tload_q     <= TIMEOUT_RESET;
    end else begin
      if (accept) begin
        baseline_q  <= baseline_d;
        lpress_q    <= lpress_d;
        save_pend_q <= save_pend_d;
        dirty_a_q   <= dirty_a_d;
        dirty_b_q   <= dirty_b_d;
        waiting_q   <= waiting_d;
        timeout_q   <= timeout_d;
        attn_q      <= attn_d;
      end
      if (cfg_valid_i) tload_q <= cfg_data_i;
    end
  end

endmodule

// ===== src/tcr_queue.sv =====
// Two-entry descriptor queue between front and back end. Uses tcr_pkg.
module tcr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcr_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcr_pkg::desc_t desc_o
);
  import tcr_pkg::*;

  desc_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign desc_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/tcr_back.sv =====
// Back end: holds the current transmit frame and sends it one byte per cycle, while
// out_ready_i is high, for each descriptor. Uses tcr_pkg.
module tcr_back #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  tcr_pkg::desc_t         desc_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_last_o,
  output logic [tcr_pkg::OUT_W-1:0] out_data_o
);
  import tcr_pkg::*;

  localparam int EMIT = (FRAME_BYTES < 16) ? FRAME_BYTES : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EMIT - 1);

  logic                   active_q, fill_q, attn_q, upd_q, sav_q;
  logic [IDX_W-1:0]       idx_q;
  logic [IMG_BYTES*8-1:0] img_q;
  logic [1:0]             status_q;
  logic                   beat;
  logic [7:0]             byte_val;

  assign out_valid_o = active_q;
  assign out_last_o  = idx_q == LAST_IDX;
  assign beat        = active_q && out_ready_i;
  assign pop_o       = q_valid_i && (!active_q || (out_ready_i && out_last_o));

  always_comb begin
    if (fill_q)                               byte_val = FILL_BYTE;
    else if (idx_q < IDX_W'(IMG_BYTES))       byte_val = img_q[{idx_q, 3'b000} +: 8];
    else                                      byte_val = 8'd0;
  end

  assign out_data_o = {7'd0, sav_q, upd_q, attn_q, byte_val, idx_q, status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      fill_q   <= 1'b1;
    end else if (pop_o) begin
      active_q <= 1'b1;
      idx_q    <= '0;
      if (desc_i.load) fill_q <= desc_i.fill;
    end else if (beat) begin
      if (out_last_o) active_q <= 1'b0;
      else            idx_q    <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= desc_i.status;
      attn_q   <= desc_i.attention;
      upd_q    <= desc_i.upd;
      sav_q    <= desc_i.sav;
      if (desc_i.load) img_q <= desc_i.img;
    end
  end

endmodule

// ===== src/touch_i2c_command_report_engine.sv =====
// Flow: with the back end idle, an item that is taken is written into the descriptor queue
// and then popped into the back end's frame registers, which offer the first byte of its frame.
// Throughput: min(FRAME_BYTES,16) bytes per item, one byte per cycle while tready is high;
// the front takes a new item while the back still sends, up to two queued descriptors.
// Reset: asynchronous, active low; frame reads all 0x5A, baseline 0, long-press 1000,
// report timeout load 100, queue empty. No clearing pass.
module touch_i2c_command_report_engine #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // code[7:0] frame_length[15:8] set_value[31:16] event_payload[55:32]
  // baseline_now[71:56] channel_now[87:72] proximity_now[103:88] gesture_now[119:104]
  // sensor_first[135:120] sensor_second[151:136] save_accepted[152], zero to 159
  input  logic [tcr_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic [1:0]                s_axis_tuser,   // mode[1:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status[1:0] byte_index[5:2] frame_byte[13:6] attention[14]
  // update_request[15] save_request[16], zero to 23
  output logic [tcr_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [15:0]               cfg_data_i    // report_timeout_load
);
  import tcr_pkg::*;

  desc_t push_desc, pop_desc;
  logic  push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  tcr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .desc_o      (push_desc),
    .full_i      (full)
  );

  tcr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (pop_desc)
  );

  tcr_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .desc_i      (pop_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== src/tcr_checker.sv =====
// Port-level checks of the result stream of touch_i2c_command_report_engine.
// Uses tcr_pkg; bound to the top level below.
module tcr_checker #(
  parameter int FRAME_BYTES = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tcr_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  import tcr_pkg::*;

  localparam int EMIT = (FRAME_BYTES < 16) ? FRAME_BYTES : 16;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EMIT - 1);

  logic beat;
  assign beat = m_axis_tvalid && m_axis_tready;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:2] == LAST_IDX)))
    else $error("tlast does not mark the final frame byte");

  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[5:2] == $past(m_axis_tdata[5:2]) + 4'd1))
    else $error("frame bytes not sent in order");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !m_axis_tlast |=>
      (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0])) &&
      (m_axis_tdata[16:14] == $past(m_axis_tdata[16:14])))
    else $error("item flags changed within a frame");

endmodule

bind touch_i2c_command_report_engine tcr_checker #(.FRAME_BYTES(FRAME_BYTES)) u_tcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of touch_i2c_command_report_engine: directed and random event items,
// each checked byte by byte against an in-bench prediction of the transmit frame.
// Depends on src/tcr_pkg.sv and src/touch_i2c_command_report_engine.sv.
`timescale 1ns / 1ps

module tb_top;
  import tcr_pkg::*;

  localparam int          FRAME_LEN   = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SHOW_MAX    = 40;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  // one input item; everything below mode is tdata, code in the lowest bits
  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  pad;
    logic        save_ok;
    logic [15:0] sensor_b;
    logic [15:0] sensor_a;
    logic [15:0] gesture;
    logic [15:0] proximity;
    logic [15:0] channel;
    logic [15:0] baseline;
    logic [23:0] payload;
    logic [15:0] set_value;
    logic [7:0]  frame_len;
    logic [7:0]  code;
  } touch_event_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] idx;
    logic [7:0] data;
    logic       last;
    logic       attn;
    logic       upd;
    logic       sav;
  } tx_byte_t;

  class frame_scoreboard;
    logic [7:0]  frame_img [FRAME_LEN];
    logic [15:0] saved_base;
    logic [15:0] lpress_time;
    logic [15:0] timeout_load;
    logic [15:0] timeout_cnt;
    bit          save_pend;
    bit          dirty_a;
    bit          dirty_b;
    bit          rpt_waiting;
    bit          attn_level;
    tx_byte_t    bytes_due [$];
    int          errors;

    function new();
      fill_frame(FILL_BYTE);
      saved_base   = '0;
      lpress_time  = LPRESS_RESET;
      timeout_load = TIMEOUT_RESET;
      timeout_cnt  = '0;
      save_pend    = 0;
      dirty_a      = 0;
      dirty_b      = 0;
      rpt_waiting  = 0;
      attn_level   = 0;
      errors       = 0;
    endfunction

    function void fill_frame(logic [7:0] b);
      foreach (frame_img[i]) frame_img[i] = b;
    endfunction

    function void put_word(int pos, logic [15:0] v);
      if (pos + 1 < FRAME_LEN) begin
        frame_img[pos]     = v[7:0];
        frame_img[pos + 1] = v[15:8];
      end
    endfunction

    function void reply(logic [7:0] rcode, logic [7:0] rstat);
      fill_frame(8'h00);
      frame_img[0] = rcode;
      frame_img[1] = rstat;
      frame_img[2] = REPLY_MARK;
    endfunction

    function logic [1:0] run_command(touch_event_t ev, output bit upd);
      upd = 0;
      if (ev.frame_len == 0 || ev.frame_len > FRAME_LEN) return STAT_BAD_LEN;
      case (ev.code)
        CMD_VERSION: begin
          fill_frame(8'h00);
          for (int i = 0; i < 8; i++) frame_img[i] = VERSION_IMG[8*i +: 8];
        end
        CMD_RD_BASE: begin
          reply(RPL_RD_BASE, 8'h00);
          put_word(3, saved_base);
        end
        CMD_RD_LPRESS: begin
          reply(RPL_RD_LPRESS, 8'h00);
          put_word(3, lpress_time);
        end
        CMD_SAVE_BASE: begin
          save_pend = 1;
          reply(RPL_SAVE_BASE, 8'h00);
        end
        CMD_WR_LPRESS: begin
          if (ev.frame_len < MIN_WR_LEN) return STAT_BAD_LEN;
          if (ev.set_value == 0) begin
            reply(RPL_WR_LPRESS, REJECT_BYTE);
          end else begin
            lpress_time = ev.set_value;
            dirty_a     = 1;
            dirty_b     = 1;
            reply(RPL_WR_LPRESS, 8'h00);
          end
        end
        CMD_FW_UPDATE: begin
          reply(RPL_FW_UPDATE, 8'h00);
          upd = 1;
        end
        CMD_SENSOR: begin
          fill_frame(8'h00);
          frame_img[0] = RPL_SENSOR;
          put_word(1, ev.sensor_a);
          put_word(3, ev.sensor_b);
        end
        default: return STAT_IGNORED;
      endcase
      return STAT_OK;
    endfunction

    function void build_report(touch_event_t ev, output bit sav);
      logic [15:0] diff;
      sav = 0;
      fill_frame(8'h00);
      frame_img[0] = ev.code;
      frame_img[1] = ev.payload[7:0];
      frame_img[2] = ev.payload[15:8];
      frame_img[3] = ev.payload[23:16];
      put_word(4, ev.baseline);
      put_word(6, ev.channel);
      put_word(8, ev.proximity);
      put_word(10, ev.gesture);
      if (save_pend) begin
        diff = (ev.baseline >= saved_base) ? ev.baseline - saved_base
                                            : saved_base - ev.baseline;
        if (diff > SAVE_THRESH) begin
          sav = 1;
          if (ev.save_ok) saved_base = ev.baseline;
        end
        save_pend = 0;
      end
      rpt_waiting = 1;
      timeout_cnt = timeout_load;
      attn_level  = 1;
    endfunction

    // accepted input item: update the state and queue the whole frame
    function void take_event(touch_event_t ev);
      logic [1:0] st;
      bit         upd;
      bit         sav;
      tx_byte_t   b;
      st  = STAT_OK;
      upd = 0;
      sav = 0;
      case (ev.mode)
        MODE_COMMAND: st = run_command(ev, upd);
        MODE_REPORT:  build_report(ev, sav);
        MODE_TX_DONE: begin
          fill_frame(FILL_BYTE);
          rpt_waiting = 0;
          timeout_cnt = '0;
          attn_level  = 0;
        end
        default: st = STAT_IGNORED;
      endcase
      for (int i = 0; i < FRAME_LEN; i++) begin
        b.status = st;
        b.idx    = i[3:0];
        b.data   = frame_img[i];
        b.last   = (i == FRAME_LEN - 1);
        b.attn   = attn_level;
        b.upd    = upd;
        b.sav    = sav;
        bytes_due.push_back(b);
      end
    endfunction

    function void set_timeout_load(logic [15:0] v);
      timeout_load = v;
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= SHOW_MAX)
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_byte(logic [OUT_W-1:0] word, logic tlast);
      tx_byte_t want;
      if (bytes_due.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: unexpected byte, expected none actual %h", $time, word);
        return;
      end
      want = bytes_due.pop_front();
      if (word[1:0] !== want.status)  flag("status", 8'(want.status), 8'(word[1:0]));
      if (word[5:2] !== want.idx)     flag("byte_index", 8'(want.idx), 8'(word[5:2]));
      if (word[13:6] !== want.data)   flag("frame_byte", want.data, word[13:6]);
      if (tlast !== want.last)        flag("last", 8'(want.last), 8'(tlast));
      if (word[14] !== want.attn)     flag("attention", 8'(want.attn), 8'(word[14]));
      if (word[15] !== want.upd)      flag("update_request", 8'(want.upd), 8'(word[15]));
      if (word[16] !== want.sav)      flag("save_request", 8'(want.sav), 8'(word[16]));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [15:0]       cfg_data_i;

  frame_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int cycles;

  touch_i2c_command_report_engine #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a long hold-off while rx_hold_left runs down
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still due", $time, sb.bytes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic touch_event_t blank_event(logic [1:0] mode, logic [7:0] code,
                                               logic [7:0] len);
    touch_event_t ev;
    ev           = '0;
    ev.mode      = mode;
    ev.code      = code;
    ev.frame_len = len;
    return ev;
  endfunction

  function automatic touch_event_t random_event(logic [15:0] saved_base);
    touch_event_t ev;
    int pick;
    ev.pad       = '0;
    ev.mode      = MODE_COMMAND;
    ev.code      = $urandom;
    ev.frame_len = $urandom;
    ev.set_value = $urandom;
    ev.payload   = $urandom;
    ev.baseline  = $urandom;
    ev.channel   = $urandom;
    ev.proximity = $urandom;
    ev.gesture   = $urandom;
    ev.sensor_a  = $urandom;
    ev.sensor_b  = $urandom;
    ev.save_ok   = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      ev.code = CMD_SAVE_BASE;
      else if (pick < 90) ev.code = $urandom_range(CMD_VERSION, CMD_SENSOR);
      else                ev.code = $urandom_range(CMD_SENSOR + 1, 255);
      pick = $urandom_range(0, 99);
      if (pick < 80)      ev.frame_len = $urandom_range(1, FRAME_LEN);
      else if (pick < 90) ev.frame_len = $urandom_range(0, MIN_WR_LEN - 1);
      else if (pick < 95) ev.frame_len = $urandom_range(FRAME_LEN + 1, 255);
      if ($urandom_range(0, 9) == 0) ev.set_value = '0;
    end else if (pick < 80) begin
      ev.mode = MODE_REPORT;
      // keep half the baselines close to the saved one to straddle the save threshold
      if ($urandom_range(0, 1))
        ev.baseline = $urandom_range(0, 1) ? saved_base + 16'($urandom_range(0, 100))
                                           : saved_base - 16'($urandom_range(0, 100));
    end else if (pick < 95) begin
      ev.mode = MODE_TX_DONE;
    end else begin
      ev.mode = MODE_UNUSED;
    end
    return ev;
  endfunction

  task automatic send_event(input touch_event_t ev);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 20);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ev[IN_W-1:0];
    s_axis_tuser  = ev.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_event(ev);
  endtask

  task automatic write_timeout_load(input logic [15:0] v);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b1;
    cfg_data_i    = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_timeout_load(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop offering the last item before waiting, so it is not taken again
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.bytes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    touch_event_t ev;
    send_event(blank_event(MODE_COMMAND, CMD_VERSION, 8'd1));
    send_event(blank_event(MODE_COMMAND, CMD_RD_BASE, 8'd16));
    send_event(blank_event(MODE_COMMAND, CMD_RD_LPRESS, 8'd2));
    // zero long-press is rejected, short frame and oversize frame are bad length
    send_event(blank_event(MODE_COMMAND, CMD_WR_LPRESS, 8'd3));
    ev = blank_event(MODE_COMMAND, CMD_WR_LPRESS, 8'd2);
    ev.set_value = 16'd5;
    send_event(ev);
    ev = blank_event(MODE_COMMAND, CMD_WR_LPRESS, 8'd255);
    ev.set_value = 16'd7;
    send_event(ev);
    ev = blank_event(MODE_COMMAND, CMD_WR_LPRESS, 8'd3);
    ev.set_value = 16'hFFFF;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_RD_LPRESS, 8'd3));
    send_event(blank_event(MODE_COMMAND, CMD_FW_UPDATE, 8'd4));
    ev = blank_event(MODE_COMMAND, CMD_SENSOR, 8'd5);
    ev.sensor_a = 16'hFFFF;
    ev.sensor_b = 16'h1234;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_SENSOR + 8'd1, 8'd5));
    send_event(blank_event(MODE_COMMAND, 8'hFF, 8'd16));
    send_event(blank_event(MODE_COMMAND, CMD_VERSION, 8'd0));
    send_event(blank_event(MODE_COMMAND, CMD_VERSION, 8'd17));
    // report with nothing pending, all fields at their maximum
    ev = '1;
    ev.mode = MODE_REPORT;
    ev.pad  = '0;
    send_event(ev);
    // save threshold: 49 away is kept, 50 away is tried and refused, then saved both ways
    send_event(blank_event(MODE_COMMAND, CMD_SAVE_BASE, 8'd1));
    ev = blank_event(MODE_REPORT, 8'h01, 8'd0);
    ev.baseline = sb.saved_base + 16'd49;
    ev.save_ok  = 1'b1;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_SAVE_BASE, 8'd1));
    ev = blank_event(MODE_REPORT, 8'h02, 8'd0);
    ev.baseline = sb.saved_base + 16'd50;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_SAVE_BASE, 8'd1));
    ev = blank_event(MODE_REPORT, 8'h03, 8'd0);
    ev.baseline = 16'hFFFF;
    ev.save_ok  = 1'b1;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_SAVE_BASE, 8'd1));
    ev = blank_event(MODE_REPORT, 8'h04, 8'd0);
    ev.save_ok = 1'b1;
    send_event(ev);
    send_event(blank_event(MODE_COMMAND, CMD_RD_BASE, 8'd1));
    send_event(blank_event(MODE_TX_DONE, 8'h00, 8'd0));
    send_event(blank_event(MODE_UNUSED, 8'h00, 8'd0));
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_event(random_event(sb.saved_base));
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    rx_hold_left  = 0;
    tx_idle_pct   = 23;
    rx_idle_pct   = 77;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    write_timeout_load(16'hFFFF);
    run_directed();
    run_random(95);

    wait_drained();
    write_timeout_load(16'($urandom));
    tx_idle_pct = 77;
    rx_idle_pct = 23;
    run_random(95);

    wait_drained();
    write_timeout_load(16'h0000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // long receiver hold-off so the engine fills up and stalls its input
    rx_hold_left = 300;
    run_random(94);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
